>>> sv/ssl_pkg.sv
package ssl_pkg;
	localparam int MAX_STEPS = 64;
	localparam int PAYLOAD_BITS = 32;
	localparam int IDX_W = $clog2(MAX_STEPS);
	localparam int CNT_W = $clog2(MAX_STEPS + 1);
	localparam int ENT_W = PAYLOAD_BITS + 1;

	typedef enum logic [3:0] {
		K_PLAY = 4'd0, K_ADD = 4'd1, K_INS_AT = 4'd2, K_INS_L = 4'd3, K_INS_R = 4'd4,
		K_COPY_L = 4'd5, K_COPY_R = 4'd6, K_MOVE_L = 4'd7, K_MOVE_R = 4'd8,
		K_ROT_L = 4'd9, K_ROT_R = 4'd10, K_DEL = 4'd11, K_CUR_L = 4'd12,
		K_CUR_R = 4'd13, K_CLEAR = 4'd14, K_NONE = 4'd15
	} kind_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DEC, S_RD, S_SHUP, S_PUT, S_SHDN, S_LAST,
		S_SWAP, S_PLAY, S_SCAN, S_DONE
	} state_t;
endpackage

>>> sv/step_sequencer_list.sv
// Channel | Dir | Handshake        | Fields
// command | in  | start, busy      | kind, position, step_data, step_rest
// result  | out | done (one cycle) | out_data through rejected, eight status fields
// One transaction at a time; busy is high from the accepting edge through the done cycle,
// so the next start is taken in the cycle after done at the earliest. A shift (insert,
// copy, delete, rotate) moves one entry at a time through the memory, alternating a read
// and a write, and play scans the following rests one entry at a time. Reset clears
// length, cursor and play position; the store itself is undefined until written. The
// receiver cannot stall: done marks the result for exactly one cycle.
module step_sequencer_list (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [3:0] kind,
	input  logic [6:0] position,
	input  logic [31:0] step_data,
	input  logic step_rest,
	output logic done,
	output logic [31:0] out_data,
	output logic out_rest,
	output logic out_valid,
	output logic [5:0] rest_run,
	output logic cycle_done,
	output logic [6:0] list_length,
	output logic [5:0] cursor_pos,
	output logic rejected
);
	import ssl_pkg::*;

	logic [ENT_W-1:0] mem [MAX_STEPS];
	logic [ENT_W-1:0] rd_q;
	logic [IDX_W-1:0] raddr, waddr;
	logic [ENT_W-1:0] wdata;
	logic we;

	state_t st_q, st_n;
	kind_t k_q;
	logic [CNT_W-1:0] cnt_q, pos_q, play_q;
	logic [IDX_W-1:0] cur_q;
	logic [CNT_W-1:0] i_q, end_q, tgt_q;
	logic [ENT_W-1:0] ent_q, hold_q;
	logic [1:0] ph_q;
	logic [5:0] run_q;
	logic odat_v_q, ocyc_q, orej_q, rst_q;
	logic [PAYLOAD_BITS-1:0] odat_q;
	logic [CNT_W-1:0] cur_w;
	logic ins_full;

	assign cur_w = CNT_W'(cur_q);
	assign ins_full = k_q >= K_ADD && k_q <= K_COPY_R && cnt_q == CNT_W'(MAX_STEPS);

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	// Insert shifts up from the top toward tgt, then writes hold at tgt.
	// Delete/rotate-left shift down; rotate-right shifts up.
	always_comb begin
		st_n = st_q;
		case (st_q)
			S_IDLE: if (start) st_n = S_DEC;
			S_DEC: begin
				st_n = S_DONE;
				if (!ins_full) begin
					case (k_q)
						K_PLAY: if (cnt_q != 0 && play_q < cnt_q) st_n = S_PLAY;
						K_ADD, K_INS_R, K_INS_AT, K_INS_L: st_n = S_SHUP;
						K_COPY_L, K_COPY_R: if (cnt_q != 0) st_n = S_RD;
						K_MOVE_L: if (cnt_q != 0 && cur_q != 0) st_n = S_SWAP;
						K_MOVE_R: if (cnt_q != 0 && cur_w + 1'b1 < cnt_q) st_n = S_SWAP;
						K_ROT_L, K_ROT_R: if (cnt_q > 1) st_n = S_RD;
						K_DEL: if (cnt_q != 0) st_n = S_SHDN;
						default: ;
					endcase
				end
			end
			S_RD: if (ph_q == 2'd1) st_n = k_q == K_ROT_L ? S_SHDN : S_SHUP;
			S_SHUP: if (i_q == tgt_q) st_n = S_PUT;
			S_SHDN: if (i_q == end_q) st_n = k_q == K_DEL ? S_LAST : S_PUT;
			S_PUT, S_LAST: st_n = S_DONE;
			S_SWAP: if (ph_q == 2'd3) st_n = S_DONE;
			S_PLAY: if (ph_q[0]) begin
				if (ph_q[1]) begin
					if (rd_q[ENT_W-1] == 1'b0 || end_q == cnt_q) st_n = S_DONE;
				end else if (rd_q[ENT_W-1] || cnt_q == CNT_W'(1)) begin
					st_n = S_DONE;
				end
			end
			S_DONE: st_n = S_IDLE;
			default: st_n = S_IDLE;
		endcase
	end

	always_comb begin
		busy = st_q != S_IDLE;
		done = st_q == S_DONE;
	end

	always_comb begin
		raddr = IDX_W'(i_q);
		waddr = IDX_W'(i_q);
		wdata = rd_q;
		we = 1'b0;
		case (st_q)
			S_SHUP: begin
				raddr = IDX_W'(i_q - 1'b1);
				waddr = IDX_W'(i_q);
				we = ph_q[0];
			end
			S_SHDN: begin
				raddr = IDX_W'(i_q + 1'b1);
				waddr = IDX_W'(i_q);
				we = ph_q[0];
			end
			S_PUT: begin
				waddr = IDX_W'(tgt_q);
				wdata = hold_q;
				we = 1'b1;
			end
			S_SWAP: begin
				raddr = ph_q == 2'd0 ? IDX_W'(i_q) : IDX_W'(tgt_q);
				waddr = ph_q == 2'd2 ? IDX_W'(tgt_q) : IDX_W'(i_q);
				wdata = ph_q == 2'd2 ? ent_q : rd_q;
				we = ph_q == 2'd2 || ph_q == 2'd3;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			k_q <= K_PLAY;
			cnt_q <= '0;
			cur_q <= '0;
			play_q <= '0;
			pos_q <= '0;
			i_q <= '0;
			end_q <= '0;
			tgt_q <= '0;
			ent_q <= '0;
			hold_q <= '0;
			ph_q <= '0;
			run_q <= '0;
			odat_v_q <= 1'b0;
			ocyc_q <= 1'b0;
			orej_q <= 1'b0;
			rst_q <= 1'b0;
			odat_q <= '0;
		end else begin
			st_q <= st_n;
			case (st_q)
				S_IDLE: if (start) begin
					k_q <= kind_t'(kind);
					pos_q <= CNT_W'(position);
					hold_q <= {step_rest, step_data[PAYLOAD_BITS-1:0]};
					odat_v_q <= 1'b0; odat_q <= '0; rst_q <= 1'b0;
					run_q <= '0; ocyc_q <= 1'b0; orej_q <= 1'b0;
					ph_q <= '0;
					if (cur_w >= cnt_q)
						cur_q <= cnt_q != 0 ? IDX_W'(cnt_q - 1'b1) : '0;
				end
				S_DEC: begin
					if (ins_full)
						orej_q <= 1'b1;
					else case (k_q)
						K_PLAY: if (cnt_q != 0) begin
							if (play_q < cnt_q)
								i_q <= play_q;
							if (play_q + 1'b1 >= cnt_q) begin
								play_q <= '0; ocyc_q <= 1'b1;
							end else play_q <= play_q + 1'b1;
						end
						K_ADD, K_INS_R, K_INS_AT, K_INS_L: begin
							if (k_q == K_INS_AT)
								tgt_q <= pos_q >= cnt_q ? cnt_q : pos_q;
							else if (k_q == K_INS_L)
								tgt_q <= cnt_q == 0 ? '0 : cur_w;
							else
								tgt_q <= cnt_q == 0 ? '0 : cur_w + 1'b1;
							i_q <= cnt_q;
						end
						K_COPY_L, K_COPY_R: if (cnt_q != 0) i_q <= cur_w;
						K_MOVE_L: if (cnt_q != 0 && cur_q != 0) begin
							i_q <= cur_w; tgt_q <= cur_w - 1'b1;
						end
						K_MOVE_R: if (cnt_q != 0 && cur_w + 1'b1 < cnt_q) begin
							i_q <= cur_w; tgt_q <= cur_w + 1'b1;
						end
						K_ROT_L: if (cnt_q > 1) i_q <= '0;
						K_ROT_R: if (cnt_q > 1) i_q <= cnt_q - 1'b1;
						K_DEL: if (cnt_q != 0) begin
							i_q <= cur_w; end_q <= cnt_q - 1'b1;
						end
						K_CUR_L: if (cur_q != 0) cur_q <= cur_q - 1'b1;
						K_CUR_R: if (cnt_q == 0) cur_q <= '0;
							else if (cur_w + 1'b1 < cnt_q) cur_q <= cur_q + 1'b1;
						K_CLEAR: begin
							cnt_q <= '0; cur_q <= '0; play_q <= '0;
						end
						default: ;
					endcase
				end
				S_RD: begin
					// Fetch one entry into hold, then start the shift.
					if (ph_q == 2'd1) begin
						hold_q <= rd_q; ph_q <= '0;
						case (k_q)
							K_COPY_L: begin
								tgt_q <= cur_w; i_q <= cnt_q;
							end
							K_COPY_R: begin
								tgt_q <= cur_w + 1'b1; i_q <= cnt_q;
							end
							K_ROT_L: begin
								tgt_q <= cnt_q - 1'b1; i_q <= '0;
								end_q <= cnt_q - 1'b1;
							end
							default: begin
								tgt_q <= '0; i_q <= cnt_q - 1'b1;
							end
						endcase
					end else
						ph_q <= ph_q + 1'b1;
				end
				S_SHUP: begin
					if (i_q != tgt_q) begin
						ph_q[0] <= ~ph_q[0];
						if (ph_q[0]) i_q <= i_q - 1'b1;
					end
				end
				S_SHDN: begin
					if (i_q != end_q) begin
						ph_q[0] <= ~ph_q[0];
						if (ph_q[0]) i_q <= i_q + 1'b1;
					end
				end
				S_PUT: begin
					if (k_q != K_ROT_L && k_q != K_ROT_R) begin
						cnt_q <= cnt_q + 1'b1;
						case (k_q)
							K_ADD, K_INS_R, K_COPY_R, K_INS_AT: cur_q <= IDX_W'(tgt_q);
							default: ;
						endcase
					end
				end
				S_LAST: begin
					cnt_q <= cnt_q - 1'b1;
					if (cur_w == cnt_q - 1'b1 && cur_q != 0) cur_q <= cur_q - 1'b1;
				end
				S_SWAP: begin
					// Read a, read b, write a to b, write b to a.
					ph_q <= ph_q + 1'b1;
					if (ph_q == 2'd1) ent_q <= rd_q;
					if (ph_q == 2'd3) cur_q <= IDX_W'(tgt_q);
				end
				S_PLAY: begin
					ph_q <= ph_q[0] ? 2'd2 : ph_q + 1'b1;
					if (ph_q[0]) begin
						if (ph_q[1]) begin
							if (rd_q[ENT_W-1] && end_q != cnt_q) begin
								if (run_q != 6'd63) run_q <= run_q + 1'b1;
								end_q <= end_q + 1'b1;
								i_q <= i_q + 1'b1 >= cnt_q ? '0 : i_q + 1'b1;
							end
						end else begin
							odat_v_q <= 1'b1;
							odat_q <= rd_q[PAYLOAD_BITS-1:0];
							rst_q <= rd_q[ENT_W-1];
							if (!rd_q[ENT_W-1]) begin
								end_q <= CNT_W'(1);
								i_q <= i_q + 1'b1 >= cnt_q ? '0 : i_q + 1'b1;
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign out_data = odat_q;
	assign out_rest = rst_q;
	assign out_valid = odat_v_q;
	assign rest_run = run_q;
	assign cycle_done = ocyc_q;
	assign list_length = cnt_q;
	assign cursor_pos = cur_q;
	assign rejected = orej_q;
endmodule

>>> tb/sv/tb_step_sequencer_list.sv
module tb_step_sequencer_list;
	timeunit 1ns;
	timeprecision 1ps;
	import ssl_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [3:0] kind = 4'd0;
	logic [6:0] position = 7'd0;
	logic [31:0] step_data = 32'd0;
	logic step_rest = 1'b0;
	logic done;
	logic [31:0] out_data;
	logic out_rest;
	logic out_valid;
	logic [5:0] rest_run;
	logic cycle_done;
	logic [6:0] list_length;
	logic [5:0] cursor_pos;
	logic rejected;

	step_sequencer_list dut (.*);

	always #4 clk = ~clk;

	typedef struct packed {
		logic [31:0] data;
		logic rest;
		logic valid;
		logic [5:0] run;
		logic cycle;
		logic [6:0] len;
		logic [5:0] cur;
		logic rej;
	} status_t;

	typedef struct {
		kind_t k;
		logic [6:0] pos;
		logic [31:0] data;
		logic rest;
		bit known;
		status_t want;
	} row_t;

	// Model of the list.
	logic [31:0] m_data [MAX_STEPS];
	logic m_rest [MAX_STEPS];
	int m_count;
	int m_cursor;
	int m_play;

	status_t pending [$];
	int errors = 0;
	int row_errors;
	int accepted;
	int results = 0;
	int plays;
	int wraps;
	int fulls;
	int idle_cycles = 0;
	bit quiet;

	function automatic void insert_step(int p, logic [31:0] d, logic r);
		if (p > m_count) p = m_count;
		for (int i = m_count; i > p; i--) begin
			m_data[i] = m_data[i - 1];
			m_rest[i] = m_rest[i - 1];
		end
		m_data[p] = d;
		m_rest[p] = r;
		m_count++;
	endfunction

	function automatic void swap_steps(int a, int b);
		logic [31:0] d;
		logic r;
		d = m_data[a];
		r = m_rest[a];
		m_data[a] = m_data[b];
		m_rest[a] = m_rest[b];
		m_data[b] = d;
		m_rest[b] = r;
	endfunction

	function automatic status_t apply_edit(kind_t k, int pos, logic [31:0] d, logic r);
		status_t s;
		logic [31:0] td;
		logic tr;
		int p;
		s = '0;
		if (m_cursor >= m_count) m_cursor = m_count ? m_count - 1 : 0;
		if (k >= K_ADD && k <= K_COPY_R && m_count >= MAX_STEPS) begin
			s.rej = 1'b1;
		end else begin
			case (k)
				K_PLAY: if (m_count != 0) begin
					if (m_play < m_count) begin
						s.valid = 1'b1;
						s.data = m_data[m_play];
						s.rest = m_rest[m_play];
						if (!m_rest[m_play]) begin
							p = m_play + 1;
							for (int n = 1; n < m_count; n++) begin
								if (p >= m_count) p = 0;
								if (!m_rest[p]) break;
								p++;
								if (s.run != 6'd63) s.run++;
							end
						end
					end
					m_play++;
					if (m_play >= m_count) begin
						m_play = 0;
						s.cycle = 1'b1;
					end
				end
				K_ADD, K_INS_R: begin
					if (m_count == 0) begin
						insert_step(0, d, r);
						m_cursor = 0;
					end else begin
						insert_step(m_cursor + 1, d, r);
						m_cursor++;
					end
				end
				K_INS_AT: begin
					if (pos >= m_count) begin
						insert_step(m_count, d, r);
						m_cursor = m_count - 1;
					end else begin
						insert_step(pos, d, r);
						m_cursor = pos;
					end
				end
				K_INS_L: insert_step(m_count == 0 ? 0 : m_cursor, d, r);
				K_COPY_L: if (m_count != 0)
					insert_step(m_cursor, m_data[m_cursor], m_rest[m_cursor]);
				K_COPY_R: if (m_count != 0) begin
					insert_step(m_cursor + 1, m_data[m_cursor], m_rest[m_cursor]);
					m_cursor++;
				end
				K_MOVE_L: if (m_count != 0 && m_cursor > 0) begin
					swap_steps(m_cursor, m_cursor - 1);
					m_cursor--;
				end
				K_MOVE_R: if (m_cursor + 1 < m_count) begin
					swap_steps(m_cursor, m_cursor + 1);
					m_cursor++;
				end
				K_ROT_L: if (m_count > 1) begin
					td = m_data[0];
					tr = m_rest[0];
					for (int i = 0; i < m_count - 1; i++) begin
						m_data[i] = m_data[i + 1];
						m_rest[i] = m_rest[i + 1];
					end
					m_data[m_count - 1] = td;
					m_rest[m_count - 1] = tr;
				end
				K_ROT_R: if (m_count > 1) begin
					td = m_data[m_count - 1];
					tr = m_rest[m_count - 1];
					for (int i = m_count - 1; i > 0; i--) begin
						m_data[i] = m_data[i - 1];
						m_rest[i] = m_rest[i - 1];
					end
					m_data[0] = td;
					m_rest[0] = tr;
				end
				K_DEL: if (m_count != 0) begin
					for (int i = m_cursor; i < m_count - 1; i++) begin
						m_data[i] = m_data[i + 1];
						m_rest[i] = m_rest[i + 1];
					end
					m_count--;
					if (m_cursor == m_count && m_cursor > 0) m_cursor--;
				end
				K_CUR_L: if (m_cursor > 0) m_cursor--;
				K_CUR_R: begin
					if (m_count == 0) m_cursor = 0;
					else if (m_cursor + 1 < m_count) m_cursor++;
				end
				K_CLEAR: begin
					m_count = 0;
					m_cursor = 0;
					m_play = 0;
				end
				default: ;
			endcase
		end
		s.len = m_count[6:0];
		s.cur = m_cursor[5:0];
		return s;
	endfunction

	task automatic issue(kind_t k, logic [6:0] pos, logic [31:0] d, logic r,
			bit known, status_t want);
		status_t s;
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 9);
			repeat (gap) @(posedge clk);
		end
		while (busy) @(posedge clk);
		start <= 1'b1;
		kind <= k;
		position <= pos;
		step_data <= d;
		step_rest <= r;
		// The block is idle here, so the transaction is taken at the next edge.
		@(posedge clk);
		s = apply_edit(k, pos, d, r);
		if (known && s != want) begin
			$display("%0t directed row disagrees with model: expected %h, model %h",
				$time, want, s);
			row_errors++;
		end
		pending = {pending, s};
		accepted++;
		if (k == K_PLAY) plays++;
		if (s.cycle) wraps++;
		if (s.rej) fulls++;
		// Drop start so the block does not take the transaction twice.
		start <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		status_t got, exp_s;
		if (done) begin
			got = '{out_data, out_rest, out_valid, rest_run, cycle_done,
				list_length, cursor_pos, rejected};
			if (pending.size() == 0) begin
				$display("%0t unexpected result %h", $time, got);
				errors++;
			end else begin
				exp_s = pending.pop_front();
				results++;
				if (got != exp_s) begin
					$display("%0t mismatch: expected %h, actual %h", $time, exp_s, got);
					if (got.data != exp_s.data)
						$display("  out_data expected %h actual %h", exp_s.data, got.data);
					if (got.run != exp_s.run)
						$display("  rest_run expected %0d actual %0d", exp_s.run, got.run);
					if (got.len != exp_s.len || got.cur != exp_s.cur)
						$display("  length/cursor expected %0d/%0d actual %0d/%0d",
							exp_s.len, exp_s.cur, got.len, got.cur);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles without any transaction.
	always @(posedge clk) begin
		if (done || (start && !busy)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic status_t st(int len, int cur, bit rej);
		status_t s;
		s = '0;
		s.len = len[6:0];
		s.cur = cur[5:0];
		s.rej = rej;
		return s;
	endfunction

	task automatic run_random(int n, int mode);
		kind_t k;
		int r;
		status_t none;
		none = '0;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (mode == 1) k = (r < 60) ? K_ADD : kind_t'($urandom_range(0, 15));
			else if (mode == 2) k = (r < 50) ? K_PLAY : kind_t'($urandom_range(0, 15));
			else if (r < 35) k = K_PLAY;
			else if (r < 55) k = kind_t'($urandom_range(1, 6));
			else if (r < 58) k = K_CLEAR;
			else k = kind_t'($urandom_range(0, 15));
			if (mode == 0 && k == K_CLEAR && $urandom_range(0, 3) != 0) k = K_DEL;
			issue(k, 7'($urandom_range(0, 127)), $urandom(),
				1'($urandom_range(0, 99) < 45), 1'b0, none);
		end
	endtask

	row_t rows [$];

	initial begin
		status_t z;
		z = '0;
		row_errors = 0;
		accepted = 0;
		plays = 0;
		wraps = 0;
		fulls = 0;
		quiet = 1'b0;
		m_count = 0;
		m_cursor = 0;
		m_play = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rows = '{
			'{K_PLAY, 7'd0, 32'd0, 1'b0, 1'b1, st(0, 0, 0)},
			'{K_CUR_R, 7'd0, 32'd0, 1'b0, 1'b1, st(0, 0, 0)},
			'{K_DEL, 7'd0, 32'd0, 1'b0, 1'b1, st(0, 0, 0)},
			'{K_COPY_L, 7'd0, 32'd0, 1'b0, 1'b1, st(0, 0, 0)},
			'{K_ROT_L, 7'd0, 32'd0, 1'b0, 1'b1, st(0, 0, 0)},
			'{K_INS_R, 7'd0, 32'hFFFFFFFF, 1'b0, 1'b1, st(1, 0, 0)},
			'{K_DEL, 7'd0, 32'd0, 1'b0, 1'b1, st(0, 0, 0)},
			'{K_INS_L, 7'd0, 32'h00000000, 1'b1, 1'b1, st(1, 0, 0)},
			'{K_ADD, 7'd0, 32'hA5A5A5A5, 1'b0, 1'b1, st(2, 1, 0)},
			'{K_INS_AT, 7'd127, 32'h5A5A5A5A, 1'b1, 1'b1, st(3, 2, 0)},
			'{K_INS_AT, 7'd0, 32'h12345678, 1'b0, 1'b0, z},
			'{K_COPY_L, 7'd0, 32'd0, 1'b0, 1'b0, z},
			'{K_COPY_R, 7'd0, 32'd0, 1'b0, 1'b0, z},
			'{K_MOVE_L, 7'd0, 32'd0, 1'b0, 1'b0, z},
			'{K_MOVE_R, 7'd0, 32'd0, 1'b0, 1'b0, z},
			'{K_ROT_L, 7'd0, 32'd0, 1'b0, 1'b0, z},
			'{K_ROT_R, 7'd0, 32'd0, 1'b0, 1'b0, z},
			'{K_CUR_L, 7'd0, 32'd0, 1'b0, 1'b0, z},
			'{K_NONE, 7'd64, 32'd0, 1'b0, 1'b0, z},
			'{K_PLAY, 7'd0, 32'd0, 1'b0, 1'b0, z},
			'{K_PLAY, 7'd0, 32'd0, 1'b0, 1'b0, z},
			'{K_DEL, 7'd0, 32'd0, 1'b0, 1'b0, z},
			'{K_PLAY, 7'd0, 32'd0, 1'b0, 1'b0, z},
			'{K_PLAY, 7'd0, 32'd0, 1'b0, 1'b0, z},
			'{K_CLEAR, 7'd0, 32'd0, 1'b0, 1'b1, st(0, 0, 0)}
		};
		foreach (rows[i])
			issue(rows[i].k, rows[i].pos, rows[i].data, rows[i].rest,
				rows[i].known, rows[i].want);

		// Fill to capacity with mostly rests so long rest runs saturate, then
		// hammer the full list with inserts and plays.
		for (int i = 0; i < MAX_STEPS; i++)
			issue(K_ADD, 7'd0, $urandom(), 1'(i != 3), 1'b0, z);
		issue(K_ADD, 7'd0, 32'd1, 1'b0, 1'b1, st(64, 63, 1));
		for (int k = K_INS_AT; k <= K_COPY_R; k++)
			issue(kind_t'(k), 7'd5, 32'd1, 1'b0, 1'b0, z);
		run_random(90, 2);
		issue(K_CLEAR, 7'd0, 32'd0, 1'b0, 1'b1, st(0, 0, 0));

		run_random(150, 1);
		run_random(270, 0);
		quiet = 1'b1;
		run_random(100, 0);

		repeat (300) @(posedge clk);
		$display("Ran %0d transactions (%0d plays, %0d wraps, %0d full-list rejects).",
			accepted, plays, wraps, fulls);
		$display("Checked %0d results, %0d mismatches.", results, errors + row_errors);
		if (errors == 0 && row_errors == 0 && pending.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
